### design/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/cps_pkg.sv
`default_nettype none
package cps_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int TIME_W      = 48;
  localparam int BYTES_W     = 16;
  localparam int BASE_W      = 50;
  localparam int AW          = 54;
  localparam int IN_W        = 4 * TIME_W + BYTES_W;
  localparam int DIV_CONST   = 1000;
  localparam int MS_SHIFT    = 10;
  localparam int WIN_W       = 11;
  localparam int PLAY_W      = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int STATUS_W    = 2;
  localparam int SLOT_DATA_W = TIME_W + BYTES_W;

  localparam logic [WIN_W-1:0]   WIN_HIGH_RST = 11'd10;
  localparam logic [WIN_W-1:0]   WIN_LOW_RST  = 11'h7f6;
  localparam logic [PLAY_W-1:0]  PLAY_OFS_RST = 11'd730;
  localparam logic [BYTES_W-1:0] CAP_RST      = 16'd4096;
  localparam logic [BYTES_W-1:0] MAX_RST      = 16'd4083;

  typedef enum logic [STATUS_W-1:0] {
    ST_TIME   = 2'd0,
    ST_PLAYED = 2'd1,
    ST_RESYNC = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_HIGH    = 3'd0,
    CFG_WIN_LOW     = 3'd1,
    CFG_PLAY_OFS    = 3'd2,
    CFG_SLOT_CAP    = 3'd3,
    CFG_MAX_PAYLOAD = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BASE,
    S_REL,
    S_DIFF,
    S_HALF,
    S_SAT,
    S_STORE,
    S_LOAD,
    S_ADDOFS,
    S_SUBSTAMP,
    S_ABS,
    S_DIV,
    S_DIVQ,
    S_DIVR,
    S_FIX,
    S_SIGN,
    S_PLAYOFS,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [WIN_W-1:0]   win_high;
    logic [WIN_W-1:0]   win_low;
    logic [PLAY_W-1:0]  play_ofs;
    logic [BYTES_W-1:0] cap_bytes;
    logic [BYTES_W-1:0] max_bytes;
  } cps_cfg_t;

endpackage
`default_nettype wire

### design/cps_ram.sv
`default_nettype none
module cps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### design/cps_alu.sv
`default_nettype none
module cps_alu (
  input  logic [cps_pkg::AW-1:0] a,
  input  logic [cps_pkg::AW-1:0] b,
  input  cps_pkg::alu_op_t       op,
  output logic [cps_pkg::AW-1:0] res
);
  import cps_pkg::*;

  always_comb begin
    case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      default: res = a + b;
    endcase
  end

endmodule
`default_nettype wire

### design/cps_ctrl.sv
`default_nettype none
module cps_ctrl #(
  parameter int SLOTS = cps_pkg::SLOTS_DEF,
  localparam int SW = $clog2(SLOTS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [cps_pkg::TIME_W-1:0]  in_local,
  input  logic [cps_pkg::TIME_W-1:0]  in_recv,
  input  logic [cps_pkg::TIME_W-1:0]  in_stamp,
  input  logic [cps_pkg::BYTES_W-1:0] in_bytes,
  input  cps_pkg::cps_cfg_t           cfg,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cps_pkg::status_t            out_status,
  output logic [SW-1:0]               out_wslot,
  output logic                        out_pvalid,
  output logic [SW-1:0]               out_pslot,
  output logic [cps_pkg::BYTES_W-1:0] out_pbytes,
  output logic                        out_prep,
  output logic [cps_pkg::TIME_W-1:0]  out_offset
);
  import cps_pkg::*;

  state_t state_r, state_nxt;

  logic [TIME_W-1:0]  local_r, recv_r, stamp_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [SW-1:0]      wslot_r;

  logic               base_known_r, base_known_nxt;
  logic [BASE_W-1:0]  base_r, base_nxt;
  logic [TIME_W-1:0]  offset_r, offset_nxt;
  logic [SW-1:0]      wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;

  logic [AW-1:0]        acc_r, acc_nxt;
  logic                 neg_r, neg_nxt;
  logic [AW-1:0]        quo_r, quo_nxt;
  logic [AW-1:0]        fold_r, fold_nxt;
  logic                 hit_r, hit_nxt;
  logic [BYTES_W-1:0]   size_r, size_nxt;

  status_t            res_status_r, res_status_nxt;
  logic               res_pvalid_r, res_pvalid_nxt;
  logic [SW-1:0]      res_pslot_r, res_pslot_nxt;
  logic [BYTES_W-1:0] res_pbytes_r, res_pbytes_nxt;
  logic               res_prep_r, res_prep_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  status_t            out_status_r;
  logic [SW-1:0]      out_wslot_r, out_pslot_r;
  logic               out_pvalid_r, out_prep_r;
  logic [BYTES_W-1:0] out_pbytes_r;
  logic [TIME_W-1:0]  out_offset_r;

  logic [AW-1:0] alu_a, alu_b, alu_res;
  alu_op_t       alu_op;

  logic                   ram_we, ram_re;
  logic [SLOT_DATA_W-1:0] ram_rdata;

  logic [AW-1:0]    local_x, recv_x, base_x, ofs_x, stamp_x, hi_x, lo_x, play_x;
  logic [AW-1:0]    fold_x, low_x;
  logic             fold_done, rem_ge, lt_hi, gt_lo, fits, accept;
  logic [TIME_W-1:0] sat;

  function automatic logic [SW-1:0] ptr_step(input logic [SW-1:0] p, input int k);
    logic [SW+1:0] s;
    s = {2'b00, p} + (SW+2)'(k);
    if (s >= (SW+2)'(SLOTS)) begin
      s = s - (SW+2)'(SLOTS);
    end
    return s[SW-1:0];
  endfunction

  cps_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (alu_op),
    .res (alu_res)
  );

  cps_ram #(
    .WIDTH (SLOT_DATA_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wslot_r),
    .wdata ({bytes_r, stamp_r}),
    .re    (ram_re),
    .raddr (rptr_r),
    .rdata (ram_rdata)
  );

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  assign local_x = {{(AW-TIME_W){1'b0}}, local_r};
  assign recv_x  = {{(AW-TIME_W){1'b0}}, recv_r};
  assign base_x  = {{(AW-BASE_W){base_r[BASE_W-1]}}, base_r};
  assign ofs_x   = {{(AW-TIME_W){offset_r[TIME_W-1]}}, offset_r};
  assign stamp_x = hit_r ? {{(AW-TIME_W){1'b0}}, ram_rdata[TIME_W-1:0]} : '0;
  assign hi_x    = {{(AW-WIN_W){cfg.win_high[WIN_W-1]}}, cfg.win_high};
  assign lo_x    = {{(AW-WIN_W){cfg.win_low[WIN_W-1]}}, cfg.win_low};
  assign play_x  = {{(AW-PLAY_W){1'b0}}, cfg.play_ofs};
  assign fold_x    = {{MS_SHIFT{1'b0}}, acc_r[AW-1:MS_SHIFT]};
  assign low_x     = {{(AW-MS_SHIFT){1'b0}}, acc_r[MS_SHIFT-1:0]};
  assign fold_done = ~|acc_r[AW-1:MS_SHIFT];
  assign rem_ge    = acc_r[MS_SHIFT-1:0] >= MS_SHIFT'(DIV_CONST);
  assign lt_hi   = $signed(acc_r) < $signed(hi_x);
  assign gt_lo   = $signed(acc_r) > $signed(lo_x);
  assign fits    = (&acc_r[AW-1:TIME_W-1]) || (~|acc_r[AW-1:TIME_W-1]);
  assign sat     = fits ? acc_r[TIME_W-1:0] :
                   (acc_r[AW-1] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}});

  always_comb begin
    state_nxt      = state_r;
    base_known_nxt = base_known_r;
    base_nxt       = base_r;
    offset_nxt     = offset_r;
    wptr_nxt       = wptr_r;
    rptr_nxt       = rptr_r;
    valid_nxt      = valid_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    quo_nxt        = quo_r;
    fold_nxt       = fold_r;
    hit_nxt        = hit_r;
    size_nxt       = size_r;
    res_status_nxt = res_status_r;
    res_pvalid_nxt = res_pvalid_r;
    res_pslot_nxt  = res_pslot_r;
    res_pbytes_nxt = res_pbytes_r;
    res_prep_nxt   = res_prep_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_load       = 1'b0;
    alu_a          = '0;
    alu_b          = '0;
    alu_op         = ALU_ADD;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_pvalid_nxt = 1'b0;
          res_pslot_nxt  = '0;
          res_pbytes_nxt = '0;
          res_prep_nxt   = 1'b0;
          state_nxt      = in_action ? S_STORE : S_BASE;
        end
      end
      // time reply
      S_BASE: begin
        alu_a  = local_x;
        alu_b  = recv_x;
        alu_op = ALU_SUB;
        if (!base_known_r) begin
          base_nxt       = alu_res[BASE_W-1:0];
          base_known_nxt = 1'b1;
        end
        state_nxt = S_REL;
      end
      S_REL: begin
        alu_a     = local_x;
        alu_b     = base_x;
        alu_op    = ALU_SUB;
        acc_nxt   = alu_res;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        alu_a     = recv_x;
        alu_b     = acc_r;
        alu_op    = ALU_SUB;
        acc_nxt   = alu_res;
        state_nxt = S_HALF;
      end
      S_HALF: begin
        // round toward zero before the arithmetic shift
        alu_a     = acc_r;
        alu_b     = {{(AW-1){1'b0}}, acc_r[AW-1]};
        alu_op    = ALU_ADD;
        acc_nxt   = {alu_res[AW-1], alu_res[AW-1:1]};
        state_nxt = S_SAT;
      end
      S_SAT: begin
        offset_nxt     = sat;
        res_status_nxt = ST_TIME;
        state_nxt      = S_DONE;
      end
      // audio chunk
      S_STORE: begin
        ram_we             = 1'b1;
        valid_nxt[wslot_r] = 1'b1;
        if (bytes_r >= cfg.cap_bytes || bytes_r > cfg.max_bytes) begin
          res_status_nxt = ST_REJECT;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        ram_re    = 1'b1;
        hit_nxt   = valid_r[rptr_r];
        alu_a     = local_x;
        alu_b     = base_x;
        alu_op    = ALU_SUB;
        acc_nxt   = alu_res;
        state_nxt = S_ADDOFS;
      end
      S_ADDOFS: begin
        alu_a     = acc_r;
        alu_b     = ofs_x;
        alu_op    = ALU_ADD;
        acc_nxt   = alu_res;
        state_nxt = S_SUBSTAMP;
      end
      S_SUBSTAMP: begin
        alu_a     = acc_r;
        alu_b     = stamp_x;
        alu_op    = ALU_SUB;
        acc_nxt   = alu_res;
        size_nxt  = hit_r ? ram_rdata[SLOT_DATA_W-1:TIME_W] : '0;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        alu_a     = '0;
        alu_b     = acc_r;
        alu_op    = ALU_SUB;
        neg_nxt   = acc_r[AW-1];
        acc_nxt   = acc_r[AW-1] ? alu_res : acc_r;
        quo_nxt   = '0;
        state_nxt = S_DIV;
      end
      // divide by the ms constant: fold the bits above the low ten back in
      // as 24 times their value (1024 - 1000 = 16 + 8)
      S_DIV: begin
        alu_a    = fold_x << 4;
        alu_b    = fold_x << 3;
        alu_op   = ALU_ADD;
        fold_nxt = alu_res;
        if (fold_done) begin
          state_nxt = S_FIX;
        end else begin
          state_nxt = S_DIVQ;
        end
      end
      S_DIVQ: begin
        alu_a     = quo_r;
        alu_b     = fold_x;
        alu_op    = ALU_ADD;
        quo_nxt   = alu_res;
        state_nxt = S_DIVR;
      end
      S_DIVR: begin
        alu_a     = low_x;
        alu_b     = fold_r;
        alu_op    = ALU_ADD;
        acc_nxt   = alu_res;
        state_nxt = S_DIV;
      end
      S_FIX: begin
        alu_a     = quo_r;
        alu_b     = {{(AW-1){1'b0}}, rem_ge};
        alu_op    = ALU_ADD;
        acc_nxt   = alu_res;
        state_nxt = S_SIGN;
      end
      S_SIGN: begin
        alu_a     = '0;
        alu_b     = acc_r;
        alu_op    = ALU_SUB;
        acc_nxt   = neg_r ? alu_res : acc_r;
        state_nxt = S_PLAYOFS;
      end
      S_PLAYOFS: begin
        alu_a     = acc_r;
        alu_b     = play_x;
        alu_op    = ALU_SUB;
        acc_nxt   = alu_res;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (lt_hi && gt_lo) begin
          res_status_nxt = ST_PLAYED;
          res_pvalid_nxt = 1'b1;
          res_pslot_nxt  = rptr_r;
          res_pbytes_nxt = size_r;
          res_prep_nxt   = (rptr_r == wslot_r);
          rptr_nxt       = ptr_step(rptr_r, 1);
        end else begin
          res_status_nxt = ST_RESYNC;
          if (lt_hi) begin
            rptr_nxt = ptr_step(rptr_r, SLOTS - 1);
          end else if (gt_lo) begin
            rptr_nxt = ptr_step(rptr_r, 2);
          end
        end
        wptr_nxt  = ptr_step(wslot_r, 1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      base_known_r <= 1'b0;
      base_r       <= '0;
      offset_r     <= '0;
      wptr_r       <= '0;
      rptr_r       <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      base_known_r <= base_known_nxt;
      base_r       <= base_nxt;
      offset_r     <= offset_nxt;
      wptr_r       <= wptr_nxt;
      rptr_r       <= rptr_nxt;
      valid_r      <= valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      local_r <= in_local;
      recv_r  <= in_recv;
      stamp_r <= in_stamp;
      bytes_r <= in_bytes;
      wslot_r <= wptr_r;
    end
    acc_r        <= acc_nxt;
    neg_r        <= neg_nxt;
    quo_r        <= quo_nxt;
    fold_r       <= fold_nxt;
    hit_r        <= hit_nxt;
    size_r       <= size_nxt;
    res_status_r <= res_status_nxt;
    res_pvalid_r <= res_pvalid_nxt;
    res_pslot_r  <= res_pslot_nxt;
    res_pbytes_r <= res_pbytes_nxt;
    res_prep_r   <= res_prep_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_wslot_r  <= wslot_r;
      out_pvalid_r <= res_pvalid_r;
      out_pslot_r  <= res_pslot_r;
      out_pbytes_r <= res_pbytes_r;
      out_prep_r   <= res_prep_r;
      out_offset_r <= offset_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_wslot  = out_wslot_r;
  assign out_pvalid = out_pvalid_r;
  assign out_pslot  = out_pslot_r;
  assign out_pbytes = out_pbytes_r;
  assign out_prep   = out_prep_r;
  assign out_offset = out_offset_r;

endmodule
`default_nettype wire

### design/chunk_playout_scheduler.sv
// jitter-buffer playout scheduler: one word in, one result word out. a time reply
// (tuser 0) sets the server time base on its first arrival and updates the clock
// offset; an audio chunk (tuser 1) is stored in the write slot and the age of the
// read slot decides between play and read-pointer resync. adds and subtracts run
// on one shared 54-bit adder under a sequencer, and the block takes no new word
// while it works. a chunk at or above the slot cap or over the max payload is
// rejected instead. the divide by 1000 folds the bits above the low ten back in
// as 24 times their value, and no chunk needs more than nine folds. the result
// sits in an output register, so the next word is accepted while it waits to be
// taken; a result that is still not taken when the next one is ready holds the
// block in its last step.
`default_nettype none
module chunk_playout_scheduler #(
  parameter int SLOTS = cps_pkg::SLOTS_DEF,
  localparam int SW = $clog2(SLOTS),
  localparam int OUT_BITS = 2 * SW + 2 + cps_pkg::BYTES_W + cps_pkg::TIME_W,
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // local_time_us, sent_time_us, received_time_us, chunk_stamp_us, chunk_bytes
  input  logic [cps_pkg::IN_W-1:0]       in_tdata,
  // action
  input  logic [0:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // write_slot, play_valid, play_slot, play_bytes, play_repeats, clock_offset_us
  output logic [OUT_W-1:0]               out_tdata,
  // status
  output logic [cps_pkg::STATUS_W-1:0]   out_tuser,
  input  logic                           cfg_wr_en,
  input  logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cps_pkg::*;

  cps_cfg_t cfg_r;

  status_t            res_status;
  logic [SW-1:0]      res_wslot, res_pslot;
  logic               res_pvalid, res_prep;
  logic [BYTES_W-1:0] res_pbytes;
  logic [TIME_W-1:0]  res_offset;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.win_high  <= WIN_HIGH_RST;
      cfg_r.win_low   <= WIN_LOW_RST;
      cfg_r.play_ofs  <= PLAY_OFS_RST;
      cfg_r.cap_bytes <= CAP_RST;
      cfg_r.max_bytes <= MAX_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WIN_HIGH:    cfg_r.win_high  <= cfg_wdata[WIN_W-1:0];
        CFG_WIN_LOW:     cfg_r.win_low   <= cfg_wdata[WIN_W-1:0];
        CFG_PLAY_OFS:    cfg_r.play_ofs  <= cfg_wdata[PLAY_W-1:0];
        CFG_SLOT_CAP:    cfg_r.cap_bytes <= cfg_wdata[BYTES_W-1:0];
        CFG_MAX_PAYLOAD: cfg_r.max_bytes <= cfg_wdata[BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cps_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_tuser[0]),
    .in_local   (in_tdata[TIME_W-1:0]),
    .in_recv    (in_tdata[3*TIME_W-1:2*TIME_W]),
    .in_stamp   (in_tdata[4*TIME_W-1:3*TIME_W]),
    .in_bytes   (in_tdata[4*TIME_W+BYTES_W-1:4*TIME_W]),
    .cfg        (cfg_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_wslot  (res_wslot),
    .out_pvalid (res_pvalid),
    .out_pslot  (res_pslot),
    .out_pbytes (res_pbytes),
    .out_prep   (res_prep),
    .out_offset (res_offset)
  );

  assign out_tdata = OUT_W'({res_offset, res_prep, res_pbytes, res_pslot, res_pvalid, res_wslot});
  assign out_tuser = res_status;

endmodule
`default_nettype wire

### design/cps_checker.sv
`default_nettype none
`include "assert_macros.svh"
module cps_checker #(
  parameter int SLOTS = cps_pkg::SLOTS_DEF,
  localparam int SW = $clog2(SLOTS),
  localparam int OUT_BITS = 2 * SW + 2 + cps_pkg::BYTES_W + cps_pkg::TIME_W,
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [OUT_W-1:0]             out_tdata,
  input wire logic [cps_pkg::STATUS_W-1:0] out_tuser
);
  import cps_pkg::*;

  localparam int PV_BIT  = SW;
  localparam int PS_LO   = SW + 1;
  localparam int PB_LO   = 2 * SW + 1;
  localparam int PR_BIT  = 2 * SW + 1 + BYTES_W;

  `CPS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready,
    "input accepted while an item is in work")

  `CPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  `CPS_ASSERT_NOW(a_play_status, clk, rst_n, out_tvalid,
    out_tdata[PV_BIT] == (out_tuser == ST_PLAYED), "play flag disagrees with status")

  `CPS_ASSERT_NOW(a_no_play_fields, clk, rst_n, out_tvalid && !out_tdata[PV_BIT],
    out_tdata[PB_LO-1:PS_LO] == '0 && out_tdata[PR_BIT-1:PB_LO] == '0 && !out_tdata[PR_BIT],
    "play fields set without playback")

endmodule

bind chunk_playout_scheduler cps_checker #(
  .SLOTS (SLOTS)
) u_cps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
